[hdl/door_servo_controller_unit_defines.svh]
// ----------------------------------------------------------------------------
// door servo controller assertion macros
// shared property templates for the assertions of the rtl
// ----------------------------------------------------------------------------
`ifndef DOOR_SERVO_CONTROLLER_UNIT_DEFINES_SVH
`define DOOR_SERVO_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("door servo controller check failed");

// next-cycle implication, disabled during reset
`define DSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("door servo controller check failed");

`endif

[hdl/dsc_pkg.sv]
// ----------------------------------------------------------------------------
// dsc_pkg
// types and constants shared by the door servo controller modules
// ----------------------------------------------------------------------------
`default_nettype none

package dsc_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int ANGLE_W    = 8;

	// register reset values
	localparam logic [15:0]        DEBOUNCE_RST = 16'd50;
	localparam logic [15:0]        MOVE_RST     = 16'd360;
	localparam logic [15:0]        OPEN_RST     = 16'd3000;
	localparam logic [ANGLE_W-1:0] STOP_RST     = 8'd90;
	localparam logic [ANGLE_W-1:0] OPEN_ANG_RST = 8'd0;
	localparam logic [ANGLE_W-1:0] CLOSE_RST    = 8'd180;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE    = 3'd0,
		REG_MOVE_TIME   = 3'd1,
		REG_OPEN_TIME   = 3'd2,
		REG_STOP_ANGLE  = 3'd3,
		REG_OPEN_ANGLE  = 3'd4,
		REG_CLOSE_ANGLE = 3'd5
	} reg_idx_t;

	// configuration register set
	typedef struct packed {
		logic [15:0]        debounce_ms;
		logic [15:0]        move_time_ms;
		logic [15:0]        open_time_ms;
		logic [ANGLE_W-1:0] stop_angle;
		logic [ANGLE_W-1:0] open_angle;
		logic [ANGLE_W-1:0] close_angle;
	} cfg_t;

	// one tick transaction
	typedef struct packed {
		logic button_level;
		logic card_seen;
		logic card_authorized;
	} tick_in_t;

	// one result transaction
	typedef struct packed {
		logic [ANGLE_W-1:0] servo_angle;
		logic               door_is_open;
		logic               green_lamp;
		logic               opened_pulse;
		logic               closed_pulse;
		logic               denied_pulse;
	} tick_out_t;

endpackage

`default_nettype wire

[hdl/door_servo_controller_unit.sv]
// ----------------------------------------------------------------------------
// door_servo_controller_unit
// millisecond-tick door controller: card, debounced button, servo and timers
// ----------------------------------------------------------------------------
// Each input transaction is one millisecond tick and yields exactly one result
// transaction. The block takes one tick per clock cycle while the result side is
// not stalled; a tick waits in the input register, and its result is then held
// in the result register until it is taken. The door state
// advances as the tick leaves the input register. A stalled result holds the
// input register, so up to two ticks are buffered. Configuration writes are
// always ready and take effect on the next processed tick; write them only
// while no tick is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "door_servo_controller_unit_defines.svh"

module door_servo_controller_unit #(
	parameter int TIMER_BITS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire dsc_pkg::tick_in_t               in_data,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output dsc_pkg::tick_out_t                   out_data,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [dsc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [dsc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	dsc_pkg::cfg_t      cfg;
	dsc_pkg::tick_in_t  tick_s1;
	dsc_pkg::tick_out_t result;
	dsc_pkg::tick_out_t out_q;
	logic               valid_s1;
	logic               out_valid_q;
	logic               step;

	assign cfg_ready = 1'b1;

	dsc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// a tick moves to the result register when that register frees up
	assign step     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step;

	dsc_tick_core #(
		.TIMER_BITS (TIMER_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.tick   (tick_s1),
		.cfg    (cfg),
		.result (result)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tick_s1 <= in_data;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// a full input register with a blocked result must stall the input
	`DSC_ASSERT_NOW(a_stall_input, clk, arst_n, valid_s1 && out_valid_q && !out_ready, !in_ready)
	// an accepted tick lands in the input register
	`DSC_ASSERT_NEXT(a_accept_loads, clk, arst_n, in_valid && in_ready, valid_s1)
	// an open door always has the green lamp lit
	`DSC_ASSERT_NOW(a_open_lamp, clk, arst_n, out_valid_q && out_q.door_is_open, out_q.green_lamp)
	// a door reported open cannot have been closed in the same tick
	`DSC_ASSERT_NOW(a_open_not_closed, clk, arst_n, out_valid_q && out_q.door_is_open, !out_q.closed_pulse)

endmodule

`default_nettype wire

[hdl/dsc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// dsc_cfg_regs
// configuration register file, written through the config channel
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	input  wire logic [dsc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [dsc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output dsc_pkg::cfg_t                        cfg
);

	dsc_pkg::cfg_t cfg_q;

	// register writes, indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms  <= dsc_pkg::DEBOUNCE_RST;
			cfg_q.move_time_ms <= dsc_pkg::MOVE_RST;
			cfg_q.open_time_ms <= dsc_pkg::OPEN_RST;
			cfg_q.stop_angle   <= dsc_pkg::STOP_RST;
			cfg_q.open_angle   <= dsc_pkg::OPEN_ANG_RST;
			cfg_q.close_angle  <= dsc_pkg::CLOSE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				dsc_pkg::REG_DEBOUNCE:    cfg_q.debounce_ms  <= cfg_data;
				dsc_pkg::REG_MOVE_TIME:   cfg_q.move_time_ms <= cfg_data;
				dsc_pkg::REG_OPEN_TIME:   cfg_q.open_time_ms <= cfg_data;
				dsc_pkg::REG_STOP_ANGLE:  cfg_q.stop_angle   <= cfg_data[dsc_pkg::ANGLE_W-1:0];
				dsc_pkg::REG_OPEN_ANGLE:  cfg_q.open_angle   <= cfg_data[dsc_pkg::ANGLE_W-1:0];
				dsc_pkg::REG_CLOSE_ANGLE: cfg_q.close_angle  <= cfg_data[dsc_pkg::ANGLE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[hdl/dsc_tick_core.sv]
// ----------------------------------------------------------------------------
// dsc_tick_core
// door state registers and the per-tick next-state and result logic
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_tick_core #(
	parameter int TIMER_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire dsc_pkg::tick_in_t   tick,
	input  wire dsc_pkg::cfg_t       cfg,
	output dsc_pkg::tick_out_t       result
);

	// compare width covers both the timers and the 16-bit limits
	localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

	logic                        open_q;
	logic [TIMER_BITS-1:0]       move_q;
	logic [TIMER_BITS-1:0]       opened_q;
	logic [TIMER_BITS-1:0]       change_q;
	logic                        prev_level_q;
	logic [dsc_pkg::ANGLE_W-1:0] servo_q;
	logic                        lamp_q;

	logic                        open_d;
	logic [TIMER_BITS-1:0]       move_d;
	logic [TIMER_BITS-1:0]       opened_d;
	logic [TIMER_BITS-1:0]       change_d;
	logic [dsc_pkg::ANGLE_W-1:0] servo_d;
	logic                        lamp_d;
	logic                        opened_p;
	logic                        closed_p;
	logic                        denied_p;
	logic                        move_done;
	logic                        stable_long;

	// one tick of door behavior, steps in priority order
	always_comb begin
		open_d   = open_q;
		lamp_d   = lamp_q;
		servo_d  = servo_q;
		opened_p = 1'b0;
		closed_p = 1'b0;
		denied_p = 1'b0;

		// saturating timers
		move_d   = (move_q   == '1) ? move_q   : move_q   + 1'b1;
		opened_d = (opened_q == '1) ? opened_q : opened_q + 1'b1;
		change_d = (change_q == '1) ? change_q : change_q + 1'b1;

		// card result
		if (tick.card_seen) begin
			if (tick.card_authorized) begin
				lamp_d = 1'b1;
				if (!open_d) begin
					servo_d  = cfg.open_angle;
					open_d   = 1'b1;
					move_d   = '0;
					opened_d = '0;
					opened_p = 1'b1;
				end
			end else begin
				denied_p = 1'b1;
			end
		end

		// button debounce and open request
		if (tick.button_level != prev_level_q) begin
			change_d = '0;
		end
		stable_long = CW'(change_d) > CW'(cfg.debounce_ms);
		move_done   = CW'(move_d) >= CW'(cfg.move_time_ms);
		if (stable_long && !tick.button_level && move_done && !open_d) begin
			servo_d  = cfg.open_angle;
			open_d   = 1'b1;
			move_d   = '0;
			opened_d = '0;
			lamp_d   = 1'b1;
			opened_p = 1'b1;
		end

		// servo stop once the move time is over
		if (CW'(move_d) >= CW'(cfg.move_time_ms)) begin
			servo_d = cfg.stop_angle;
		end

		// automatic close
		if (open_d && (CW'(opened_d) >= CW'(cfg.open_time_ms))) begin
			servo_d  = cfg.close_angle;
			open_d   = 1'b0;
			move_d   = '0;
			lamp_d   = 1'b0;
			closed_p = 1'b1;
		end
	end

	// state update on each processed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q       <= 1'b0;
			move_q       <= '1;
			opened_q     <= '0;
			change_q     <= '1;
			prev_level_q <= 1'b1;
			servo_q      <= dsc_pkg::STOP_RST;
			lamp_q       <= 1'b0;
		end else if (step) begin
			open_q       <= open_d;
			move_q       <= move_d;
			opened_q     <= opened_d;
			change_q     <= change_d;
			prev_level_q <= tick.button_level;
			servo_q      <= servo_d;
			lamp_q       <= lamp_d;
		end
	end

	assign result.servo_angle  = servo_d;
	assign result.door_is_open = open_d;
	assign result.green_lamp   = lamp_d;
	assign result.opened_pulse = opened_p;
	assign result.closed_pulse = closed_p;
	assign result.denied_pulse = denied_p;

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for door_servo_controller_unit
// ----------------------------------------------------------------------------
// Ticks go in over the valid/ready input channel, and each accepted tick is
// run through a local copy of the door logic to predict its result. A
// monitor compares every result transaction, field by field, with the oldest
// prediction. Short directed tests cover the special cases. Random traffic
// then follows under several register settings: button presses with bounce,
// releases, cards, long waits and noise. Both sides of the block idle at
// random.
// ----------------------------------------------------------------------------

module tb_top;

	localparam int TIMER_BITS = 16;

	// indexes that map to no register
	localparam logic [dsc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [dsc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef logic [TIMER_BITS-1:0] timer_t;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_ready;
	dsc_pkg::tick_in_t              in_data;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	dsc_pkg::tick_out_t             out_data;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [dsc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [dsc_pkg::CFG_DATA_W-1:0] cfg_data;

	// door state as the bench predicts it
	dsc_pkg::cfg_t               door_cfg;
	logic                        door_open;
	timer_t                      since_move;
	timer_t                      since_open;
	timer_t                      since_change;
	logic                        last_level;
	logic [dsc_pkg::ANGLE_W-1:0] servo_cmd;
	logic                        lamp_on;

	dsc_pkg::tick_out_t predicted_q[$];

	int  errors;
	int  n_sent;
	int  n_checked;
	int  n_settings;
	int  n_opened;
	int  n_closed;
	int  n_denied;
	bit  gaps_on;
	bit  stalls_on;
	logic level_now;

	door_servo_controller_unit #(
		.TIMER_BITS(TIMER_BITS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

	// door state after reset
	function automatic void reset_door_model();
		door_cfg.debounce_ms  = dsc_pkg::DEBOUNCE_RST;
		door_cfg.move_time_ms = dsc_pkg::MOVE_RST;
		door_cfg.open_time_ms = dsc_pkg::OPEN_RST;
		door_cfg.stop_angle   = dsc_pkg::STOP_RST;
		door_cfg.open_angle   = dsc_pkg::OPEN_ANG_RST;
		door_cfg.close_angle  = dsc_pkg::CLOSE_RST;
		door_open    = 1'b0;
		since_move   = '1;
		since_open   = '0;
		since_change = '1;
		last_level   = 1'b1;
		servo_cmd    = dsc_pkg::STOP_RST;
		lamp_on      = 1'b0;
	endfunction

	function automatic timer_t sat_inc(input timer_t t);
		return (t == '1) ? t : t + 1'b1;
	endfunction

	function automatic void open_door();
		servo_cmd  = door_cfg.open_angle;
		door_open  = 1'b1;
		since_move = '0;
		since_open = '0;
		lamp_on    = 1'b1;
	endfunction

	// one millisecond tick of the door logic
	function automatic dsc_pkg::tick_out_t predict_tick(input dsc_pkg::tick_in_t t);
		dsc_pkg::tick_out_t r;
		logic      opened;
		logic      closed;
		logic      denied;
		opened = 1'b0;
		closed = 1'b0;
		denied = 1'b0;
		since_move   = sat_inc(since_move);
		since_open   = sat_inc(since_open);
		since_change = sat_inc(since_change);
		// card first
		if (t.card_seen) begin
			if (t.card_authorized) begin
				lamp_on = 1'b1;
				if (!door_open) begin
					open_door();
					opened = 1'b1;
				end
			end else begin
				denied = 1'b1;
			end
		end
		// debounced button
		if (t.button_level != last_level)
			since_change = '0;
		if (since_change > door_cfg.debounce_ms && !t.button_level &&
				since_move >= door_cfg.move_time_ms && !door_open) begin
			open_door();
			opened = 1'b1;
		end
		last_level = t.button_level;
		// servo stop after the move time
		if (since_move >= door_cfg.move_time_ms)
			servo_cmd = door_cfg.stop_angle;
		// automatic close
		if (door_open && since_open >= door_cfg.open_time_ms) begin
			servo_cmd  = door_cfg.close_angle;
			door_open  = 1'b0;
			since_move = '0;
			lamp_on    = 1'b0;
			closed     = 1'b1;
		end
		r.servo_angle  = servo_cmd;
		r.door_is_open = door_open;
		r.green_lamp   = lamp_on;
		r.opened_pulse = opened;
		r.closed_pulse = closed;
		r.denied_pulse = denied;
		return r;
	endfunction

	function automatic dsc_pkg::tick_in_t make_tick(input logic lvl, input logic seen,
			input logic auth);
		dsc_pkg::tick_in_t t;
		t.button_level    = lvl;
		t.card_seen       = seen;
		t.card_authorized = auth;
		return t;
	endfunction

	function automatic logic [dsc_pkg::ANGLE_W-1:0] rand_angle();
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(181, 255));
		return 8'($urandom_range(0, 180));
	endfunction

	// random upper byte on angle writes, the register keeps the low byte
	function automatic logic [dsc_pkg::CFG_DATA_W-1:0] pad_angle(
			input logic [dsc_pkg::ANGLE_W-1:0] a);
		logic [dsc_pkg::CFG_DATA_W-1:0] w;
		w = 16'($urandom);
		w[dsc_pkg::ANGLE_W-1:0] = a;
		return w;
	endfunction

	function automatic dsc_pkg::cfg_t rand_cfg(input int unsigned span);
		dsc_pkg::cfg_t c;
		c.debounce_ms  = 16'($urandom_range(0, span / 2));
		c.move_time_ms = 16'($urandom_range(0, span));
		c.open_time_ms = 16'($urandom_range(0, 4 * span));
		c.stop_angle   = rand_angle();
		c.open_angle   = rand_angle();
		c.close_angle  = rand_angle();
		return c;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	// ready side of the result channel
	always @(negedge clk) begin
		out_ready <= stalls_on ? ($urandom_range(0, 99) >= 33) : 1'b1;
	end

	// result monitor
	always @(posedge clk) begin : result_check
		dsc_pkg::tick_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (predicted_q.size() == 0) begin
				$error("result transaction with no tick pending: %p", out_data);
				errors++;
			end else begin
				want = predicted_q.pop_front();
				check_field("servo_angle", want.servo_angle, out_data.servo_angle);
				check_field("door_is_open", 8'(want.door_is_open),
					8'(out_data.door_is_open));
				check_field("green_lamp", 8'(want.green_lamp), 8'(out_data.green_lamp));
				check_field("opened_pulse", 8'(want.opened_pulse),
					8'(out_data.opened_pulse));
				check_field("closed_pulse", 8'(want.closed_pulse),
					8'(out_data.closed_pulse));
				check_field("denied_pulse", 8'(want.denied_pulse),
					8'(out_data.denied_pulse));
				n_checked++;
				n_opened += int'(want.opened_pulse);
				n_closed += int'(want.closed_pulse);
				n_denied += int'(want.denied_pulse);
			end
		end
	end

	// one tick transaction, entered and left at a falling edge
	task automatic send_tick(input dsc_pkg::tick_in_t t);
		while (gaps_on && $urandom_range(0, 99) < 33) begin
			in_valid <= 1'b0;
			in_data  <= 3'($urandom_range(0, 7));
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= t;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted_q.push_back(predict_tick(t));
		n_sent++;
		@(negedge clk);
	endtask

	// stop sending and let every pending result come out
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (predicted_q.size() != 0)
			@(negedge clk);
	endtask

	// one register write, valid stays up for a following write
	task automatic cfg_write(input logic [dsc_pkg::CFG_IDX_W-1:0] idx,
			input logic [dsc_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			dsc_pkg::REG_DEBOUNCE:    door_cfg.debounce_ms  = val;
			dsc_pkg::REG_MOVE_TIME:   door_cfg.move_time_ms = val;
			dsc_pkg::REG_OPEN_TIME:   door_cfg.open_time_ms = val;
			dsc_pkg::REG_STOP_ANGLE:  door_cfg.stop_angle   = val[dsc_pkg::ANGLE_W-1:0];
			dsc_pkg::REG_OPEN_ANGLE:  door_cfg.open_angle   = val[dsc_pkg::ANGLE_W-1:0];
			dsc_pkg::REG_CLOSE_ANGLE: door_cfg.close_angle  = val[dsc_pkg::ANGLE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic apply_config(input dsc_pkg::cfg_t c);
		cfg_write(dsc_pkg::REG_DEBOUNCE, c.debounce_ms);
		cfg_write(dsc_pkg::REG_MOVE_TIME, c.move_time_ms);
		cfg_write(dsc_pkg::REG_OPEN_TIME, c.open_time_ms);
		cfg_write(dsc_pkg::REG_STOP_ANGLE, pad_angle(c.stop_angle));
		cfg_write(dsc_pkg::REG_OPEN_ANGLE, pad_angle(c.open_angle));
		cfg_write(dsc_pkg::REG_CLOSE_ANGLE, pad_angle(c.close_angle));
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	// reset values: idle, refused card, stray verdict bit, card with button, card while open
	task automatic test_reset_settings();
		send_tick(make_tick(1'b1, 1'b0, 1'b0));
		send_tick(make_tick(1'b1, 1'b1, 1'b0));
		send_tick(make_tick(1'b1, 1'b0, 1'b1));
		send_tick(make_tick(1'b0, 1'b1, 1'b1));
		send_tick(make_tick(1'b1, 1'b1, 1'b1));
		send_tick(make_tick(1'b0, 1'b1, 1'b0));
		level_now = 1'b0;
	endtask

	// writes to unmapped indexes change nothing
	task automatic test_spare_registers();
		wait_idle();
		cfg_write(REG_SPARE_LO, 16'($urandom));
		cfg_write(REG_SPARE_HI, 16'($urandom));
		cfg_valid <= 1'b0;
		send_tick(make_tick(1'b0, 1'b0, 1'b0));
		send_tick(make_tick(1'b1, 1'b1, 1'b0));
		level_now = 1'b1;
	endtask

	// zero times: open and close in one tick, button opens right after its edge
	task automatic test_zero_timing();
		dsc_pkg::cfg_t c;
		c.debounce_ms  = '0;
		c.move_time_ms = '0;
		c.open_time_ms = '0;
		c.stop_angle   = 8'hFF;
		c.open_angle   = 8'h00;
		c.close_angle  = 8'd180;
		wait_idle();
		apply_config(c);
		send_tick(make_tick(1'b1, 1'b1, 1'b1));
		send_tick(make_tick(1'b0, 1'b0, 1'b0));
		send_tick(make_tick(1'b0, 1'b0, 1'b0));
		send_tick(make_tick(1'b0, 1'b0, 1'b0));
		send_tick(make_tick(1'b1, 1'b0, 1'b0));
		level_now = 1'b1;
	endtask

	// all-ones times: the button never opens, the servo never stops
	task automatic test_timer_limits();
		dsc_pkg::cfg_t c;
		c.debounce_ms  = '1;
		c.move_time_ms = '1;
		c.open_time_ms = '1;
		c.stop_angle   = 8'd0;
		c.open_angle   = 8'd180;
		c.close_angle  = 8'd255;
		wait_idle();
		apply_config(c);
		repeat (4)
			send_tick(make_tick(1'b0, 1'b0, 1'b0));
		send_tick(make_tick(1'b1, 1'b1, 1'b0));
		send_tick(make_tick(1'b1, 1'b1, 1'b1));
		send_tick(make_tick(1'b0, 1'b1, 1'b1));
		send_tick(make_tick(1'b1, 1'b0, 1'b0));
		level_now = 1'b1;
	endtask

	// random sequences: bouncy presses, releases, cards, waits and noise
	task automatic run_random_phase(input dsc_pkg::cfg_t c, input int unsigned n_ticks,
			input bit idle);
		int unsigned       sent0;
		int unsigned       kind;
		int unsigned       len;
		int unsigned       wait_cap;
		dsc_pkg::tick_in_t t;
		wait_idle();
		apply_config(c);
		gaps_on   = idle;
		stalls_on = idle;
		sent0     = n_sent;
		wait_cap  = c.open_time_ms + c.move_time_ms + 4;
		if (wait_cap > 200)
			wait_cap = 200;
		while (n_sent - sent0 < n_ticks) begin
			kind = $urandom_range(0, 99);
			if (kind < 35) begin
				// press with some bounce first
				len = $urandom_range(0, 3);
				repeat (len) begin
					level_now = ~level_now;
					send_tick(make_tick(level_now, 1'b0, 1'b0));
				end
				level_now = 1'b0;
				len = $urandom_range(1, c.debounce_ms + c.move_time_ms + 8);
				repeat (len)
					send_tick(make_tick(1'b0, $urandom_range(0, 19) == 0,
						1'($urandom_range(0, 1))));
			end else if (kind < 55) begin
				level_now = 1'b1;
				len = $urandom_range(1, c.debounce_ms + 5);
				repeat (len)
					send_tick(make_tick(1'b1, 1'b0, 1'($urandom_range(0, 1))));
			end else if (kind < 75) begin
				send_tick(make_tick(level_now, 1'b1, 1'($urandom_range(0, 1))));
			end else if (kind < 90) begin
				len = $urandom_range(1, wait_cap);
				repeat (len)
					send_tick(make_tick(level_now, 1'b0, 1'b0));
			end else begin
				len = $urandom_range(1, 6);
				repeat (len) begin
					t = 3'($urandom_range(0, 7));
					level_now = t.button_level;
					send_tick(t);
				end
			end
		end
	endtask

	task automatic test_random_traffic();
		// first stretch runs with no idling on either side
		run_random_phase(rand_cfg(12), 300, 1'b0);
		run_random_phase(rand_cfg(12), 300, 1'b1);
		run_random_phase(rand_cfg(4), 250, 1'b1);
		run_random_phase(rand_cfg(30), 300, 1'b1);
		run_random_phase(rand_cfg(90), 350, 1'b1);
	endtask

	// main sequence
	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		gaps_on    = 1'b0;
		stalls_on  = 1'b0;
		level_now  = 1'b1;
		errors     = 0;
		n_sent     = 0;
		n_checked  = 0;
		n_settings = 0;
		n_opened   = 0;
		n_closed   = 0;
		n_denied   = 0;
		reset_door_model();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_settings();
		test_spare_registers();
		test_zero_timing();
		test_timer_limits();
		test_random_traffic();

		wait_idle();
		repeat (8) @(posedge clk);
		if (predicted_q.size() != 0) begin
			$error("%0d predicted results never arrived", predicted_q.size());
			errors++;
		end
		$display("%0d ticks sent under %0d register settings, %0d results compared",
			n_sent, n_settings, n_checked);
		$display("door opened %0d times, closed %0d times, %0d cards refused, %0d mismatches",
			n_opened, n_closed, n_denied, errors);
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
